// File: sv/mono_framebuffer_draw_engine_assert.svh
// Assertion macros used by the checker file.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFDE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MFDE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/mfde_pkg.sv
package mfde_pkg;

	localparam int MAX_WIDTH    = 128;
	localparam int MAX_PAGES    = 8;
	localparam int BUFFER_BYTES = 1024;

	localparam int ADDR_W = $clog2(BUFFER_BYTES);
	localparam int U_W    = $clog2(BUFFER_BYTES + 1);
	localparam int W_W    = $clog2(MAX_WIDTH + 1);
	localparam int H_W    = $clog2(MAX_PAGES * 8 + 1);
	localparam int PG_W   = $clog2(MAX_PAGES + 1);
	localparam int CRD_W  = 12;
	localparam int LEN_W  = 10;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [2:0] FUNC_PIXEL  = 3'd0;
	localparam logic [2:0] FUNC_LINE   = 3'd1;
	localparam logic [2:0] FUNC_RECT   = 3'd2;
	localparam logic [2:0] FUNC_CIRCLE = 3'd3;
	localparam logic [2:0] FUNC_FILL   = 3'd4;
	localparam logic [2:0] FUNC_READ   = 3'd5;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;

	typedef enum logic [2:0] {
		CMD_PIXEL,
		CMD_LINE,
		CMD_RECT,
		CMD_CIRCLE,
		CMD_FILL,
		CMD_READ,
		CMD_NOP
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [8:0]  xs;
		logic signed [8:0]  ys;
		logic signed [8:0]  xe;
		logic signed [8:0]  ye;
		logic [7:0]         rw;
		logic [7:0]         rh;
		logic [7:0]         rad;
		logic               filled;
		logic               white;
		logic [9:0]         bidx;
	} cmd_entry_t;

	typedef struct packed {
		logic       valid;
		cmd_entry_t entry;
	} queue_head_t;

	typedef struct packed {
		logic pop;
		logic clear_done;
	} back_status_t;

endpackage

// File: sv/mfde_ram.sv
module mfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: sv/mfde_front.sv
module mfde_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [71:0]            s_axis_tdata,
	input  logic [2:0]             s_axis_tuser,
	output mfde_pkg::queue_head_t  head,
	input  mfde_pkg::back_status_t status
);
	import mfde_pkg::*;

	cmd_entry_t        entry;
	cmd_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;

	always_comb begin
		unique case (s_axis_tuser)
			FUNC_PIXEL:  entry.cmd = CMD_PIXEL;
			FUNC_LINE:   entry.cmd = CMD_LINE;
			FUNC_RECT:   entry.cmd = CMD_RECT;
			FUNC_CIRCLE: entry.cmd = CMD_CIRCLE;
			FUNC_FILL:   entry.cmd = CMD_FILL;
			FUNC_READ:   entry.cmd = CMD_READ;
			default:     entry.cmd = CMD_NOP;
		endcase
		entry.xs     = s_axis_tdata[8:0];
		entry.ys     = s_axis_tdata[17:9];
		entry.xe     = s_axis_tdata[26:18];
		entry.ye     = s_axis_tdata[35:27];
		entry.rw     = s_axis_tdata[43:36];
		entry.rh     = s_axis_tdata[51:44];
		entry.rad    = s_axis_tdata[59:52];
		entry.filled = s_axis_tdata[60];
		entry.white  = s_axis_tdata[61];
		entry.bidx   = s_axis_tdata[71:62];
	end

	assign s_axis_tready = (count_q != QCNT_W'(QDEPTH)) && status.clear_done;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign head.valid    = (count_q != '0);
	assign head.entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (status.pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(status.pop);
		end
	end

endmodule

// File: sv/mfde_back.sv
module mfde_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mfde_pkg::queue_head_t  head,
	output mfde_pkg::back_status_t status,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [7:0]             cfg_data,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [15:0]            m_axis_tdata
);
	import mfde_pkg::*;

	localparam int M_W    = 16;
	localparam int ERR_W  = CRD_W + 1;
	localparam int IDXF_W = CRD_W + W_W;
	localparam int M_INIT = 5;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_SETUP, ST_PX_RD, ST_PX_WR, ST_ADV,
		ST_FILL, ST_RD1, ST_RD2, ST_RES
	} state_t;

	state_t                   state_q;
	logic [7:0]               fw_q;
	logic [6:0]               fh_q;
	cmd_t                     cmd_q;
	logic                     fill_q, white_q;
	logic signed [CRD_W-1:0]  ax_q, ay_q, bx_q, by_q, dx_q, dy_q, cxv_q, cyv_q;
	logic                     sx_neg_q, sy_neg_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [M_W-1:0]    m_q;
	logic [7:0]               rw_q, rh_q, row_q;
	logic [2:0]               phase_q;
	logic [9:0]               bidx_q;
	logic [7:0]               rb_q;
	logic                     ok_q;
	logic signed [CRD_W-1:0]  seg_x_q, seg_y_q;
	logic [LEN_W-1:0]         seg_len_q, seg_cnt_q;
	logic                     seg_vert_q;
	logic [U_W-1:0]           sweep_q;
	logic [ADDR_W-1:0]        addr_q;
	logic [2:0]               bit_q;
	logic                     out_valid_q, out_ok_q;
	logic [7:0]               out_byte_q;

	logic [W_W-1:0]           act_w;
	logic [H_W-1:0]           act_h;
	logic [PG_W-1:0]          pages;
	logic [U_W+W_W-1:0]       used_raw;
	logic [U_W-1:0]           used;
	logic signed [CRD_W-1:0]  px, py;
	logic [IDXF_W-1:0]        idx_full;
	logic                     pix_ok;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_addr;
	logic [7:0]               ram_wdata, ram_rdata;
	logic [7:0]               bit_mask;

	logic signed [CRD_W-1:0]  n_x, n_y;
	logic [LEN_W-1:0]         n_len;
	logic                     n_vert;

	cmd_entry_t               e;
	logic signed [CRD_W-1:0]  ldx, ldy;
	logic signed [ERR_W:0]    e2;
	logic                     c1, c2;
	logic signed [CRD_W-1:0]  y1, x1;
	logic signed [M_W-1:0]    m1, m2;

	function automatic logic signed [CRD_W-1:0] w8(input logic signed [CRD_W-1:0] v);
		w8 = $signed({{(CRD_W-8){1'b0}}, v[7:0]});
	endfunction

	function automatic logic [LEN_W-1:0] dbl2(input logic signed [CRD_W-1:0] v);
		dbl2 = {v[LEN_W-2:0], 1'b0} + LEN_W'(2);
	endfunction

	assign e = head.entry;
	assign cfg_ready = 1'b1;
	assign status.pop = (state_q == ST_IDLE) && head.valid;
	assign status.clear_done = (state_q != ST_CLR);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'd0, out_ok_q, out_byte_q};

	always_comb begin
		act_w = (9'(fw_q) < 9'(MAX_WIDTH)) ? W_W'(fw_q) : W_W'(MAX_WIDTH);
		act_h = (8'(fh_q) < 8'(MAX_PAGES * 8)) ? H_W'(fh_q) : H_W'(MAX_PAGES * 8);
		pages = PG_W'((9'(act_h) + 9'd7) >> 3);
		used_raw = (U_W+W_W)'(pages) * (U_W+W_W)'(act_w);
		used = (used_raw < (U_W+W_W)'(BUFFER_BYTES)) ? U_W'(used_raw) : U_W'(BUFFER_BYTES);
	end

	always_comb begin
		px = seg_x_q + (seg_vert_q ? '0 : $signed({{(CRD_W-LEN_W){1'b0}}, seg_cnt_q}));
		py = seg_y_q + (seg_vert_q ? $signed({{(CRD_W-LEN_W){1'b0}}, seg_cnt_q}) : '0);
		idx_full = IDXF_W'(py[CRD_W-1:3]) * IDXF_W'(act_w) + IDXF_W'(px);
		pix_ok = !px[CRD_W-1] && !py[CRD_W-1] && (px < $signed(CRD_W'(act_w)))
			&& (py < $signed(CRD_W'(act_h))) && (idx_full < IDXF_W'(BUFFER_BYTES));
	end

	always_comb begin
		n_x = ax_q;
		n_y = ay_q;
		n_len = LEN_W'(1);
		n_vert = 1'b0;
		case (cmd_q)
			CMD_RECT: begin
				if (fill_q) begin
					n_y = w8(ay_q + $signed(CRD_W'(row_q)));
					n_len = LEN_W'(rw_q);
				end else begin
					case (phase_q)
						3'd0: n_len = LEN_W'(rw_q);
						3'd1: begin
							n_y = w8(ay_q + $signed(CRD_W'(rh_q)) - CRD_W'(1));
							n_len = LEN_W'(rw_q);
						end
						3'd2: begin
							n_vert = 1'b1;
							n_len = LEN_W'(rh_q);
						end
						default: begin
							n_x = w8(ax_q + $signed(CRD_W'(rw_q)) - CRD_W'(1));
							n_vert = 1'b1;
							n_len = LEN_W'(rh_q);
						end
					endcase
				end
			end
			CMD_CIRCLE: begin
				if (fill_q) begin
					case (phase_q)
						3'd0: begin
							n_x = w8(ax_q - cxv_q); n_y = w8(ay_q + cyv_q); n_len = dbl2(cxv_q);
						end
						3'd1: begin
							n_x = w8(ax_q - cyv_q); n_y = w8(ay_q + cxv_q); n_len = dbl2(cyv_q);
						end
						3'd2: begin
							n_x = w8(ax_q - cyv_q); n_y = w8(ay_q - cxv_q); n_len = dbl2(cyv_q);
						end
						default: begin
							n_x = w8(ax_q - cxv_q); n_y = w8(ay_q - cyv_q); n_len = dbl2(cxv_q);
						end
					endcase
				end else begin
					case (phase_q)
						3'd0: begin n_x = ax_q + cxv_q; n_y = ay_q + cyv_q; end
						3'd1: begin n_x = ax_q + cyv_q; n_y = ay_q + cxv_q; end
						3'd2: begin n_x = ax_q - cxv_q; n_y = ay_q + cyv_q; end
						3'd3: begin n_x = ax_q - cyv_q; n_y = ay_q + cxv_q; end
						3'd4: begin n_x = ax_q + cxv_q; n_y = ay_q - cyv_q; end
						3'd5: begin n_x = ax_q + cyv_q; n_y = ay_q - cxv_q; end
						3'd6: begin n_x = ax_q - cxv_q; n_y = ay_q - cyv_q; end
						default: begin n_x = ax_q - cyv_q; n_y = ay_q - cxv_q; end
					endcase
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		ldx = CRD_W'(e.xe) - CRD_W'(e.xs);
		ldy = CRD_W'(e.ye) - CRD_W'(e.ys);
		ldx = ldx[CRD_W-1] ? -ldx : ldx;
		ldy = ldy[CRD_W-1] ? ldy : -ldy;
		e2 = {err_q, 1'b0};
		c1 = e2 >= (ERR_W+1)'(dy_q);
		c2 = e2 <= (ERR_W+1)'(dx_q);
		y1 = (m_q > 0) ? cyv_q - CRD_W'(1) : cyv_q;
		m1 = (m_q > 0) ? m_q - $signed(M_W'(y1) <<< 3) : m_q;
		x1 = cxv_q + CRD_W'(1);
		m2 = m1 + $signed(M_W'(x1) <<< 3) + M_W'(4);
	end

	always_comb begin
		bit_mask = 8'(1) << bit_q;
		ram_we = 1'b0;
		ram_addr = idx_full[ADDR_W-1:0];
		ram_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
				ram_addr = sweep_q[ADDR_W-1:0];
			end
			ST_FILL: begin
				ram_we = (sweep_q != used);
				ram_addr = sweep_q[ADDR_W-1:0];
				ram_wdata = {8{white_q}};
			end
			ST_PX_WR: begin
				ram_we = 1'b1;
				ram_addr = addr_q;
				ram_wdata = white_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
			end
			ST_RD1: ram_addr = ADDR_W'(bidx_q);
			default: ;
		endcase
	end

	mfde_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			fw_q        <= 8'(MAX_WIDTH);
			fh_q        <= 7'(MAX_PAGES * 8);
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_WIDTH:  fw_q <= cfg_data;
					CFG_HEIGHT: fh_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (m_axis_tready && state_q != ST_RES) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == U_W'(BUFFER_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						cmd_q    <= e.cmd;
						fill_q   <= e.filled;
						white_q  <= e.white;
						if (e.cmd == CMD_RECT) begin
							ax_q <= w8(CRD_W'(e.xs));
							ay_q <= w8(CRD_W'(e.ys));
						end else begin
							ax_q <= CRD_W'(e.xs);
							ay_q <= CRD_W'(e.ys);
						end
						bx_q     <= CRD_W'(e.xe);
						by_q     <= CRD_W'(e.ye);
						dx_q     <= ldx;
						dy_q     <= ldy;
						err_q    <= ERR_W'(ldx) + ERR_W'(ldy);
						sx_neg_q <= !(e.xs < e.xe);
						sy_neg_q <= !(e.ys < e.ye);
						rw_q     <= e.rw;
						rh_q     <= e.rh;
						row_q    <= '0;
						phase_q  <= '0;
						cxv_q    <= '0;
						cyv_q    <= CRD_W'(e.rad);
						m_q      <= M_W'(M_INIT) - M_W'({e.rad, 2'b00});
						bidx_q   <= e.bidx;
						rb_q     <= '0;
						ok_q     <= 1'b1;
						sweep_q  <= '0;
						unique case (e.cmd)
							CMD_FILL: state_q <= ST_FILL;
							CMD_READ: state_q <= ST_RD1;
							CMD_NOP:  state_q <= ST_RES;
							CMD_RECT: state_q <= (e.filled && e.rh == '0) ? ST_RES : ST_SETUP;
							default:  state_q <= ST_SETUP;
						endcase
					end
				end
				ST_SETUP: begin
					seg_x_q    <= n_x;
					seg_y_q    <= n_y;
					seg_len_q  <= n_len;
					seg_vert_q <= n_vert;
					seg_cnt_q  <= '0;
					state_q    <= ST_PX_RD;
				end
				ST_PX_RD: begin
					if (seg_cnt_q == seg_len_q) begin
						state_q <= ST_ADV;
					end else if (pix_ok) begin
						addr_q  <= idx_full[ADDR_W-1:0];
						bit_q   <= py[2:0];
						state_q <= ST_PX_WR;
					end else begin
						seg_cnt_q <= seg_cnt_q + 1'b1;
					end
				end
				ST_PX_WR: begin
					seg_cnt_q <= seg_cnt_q + 1'b1;
					state_q   <= ST_PX_RD;
				end
				ST_ADV: begin
					unique case (cmd_q)
						CMD_LINE: begin
							if (ax_q == bx_q && ay_q == by_q) begin
								state_q <= ST_RES;
							end else begin
								err_q <= err_q + (c1 ? ERR_W'(dy_q) : '0)
									+ (c2 ? ERR_W'(dx_q) : '0);
								if (c1) begin
									ax_q <= sx_neg_q ? ax_q - CRD_W'(1) : ax_q + CRD_W'(1);
								end
								if (c2) begin
									ay_q <= sy_neg_q ? ay_q - CRD_W'(1) : ay_q + CRD_W'(1);
								end
								state_q <= ST_SETUP;
							end
						end
						CMD_RECT: begin
							if (fill_q) begin
								row_q   <= row_q + 1'b1;
								state_q <= (9'(row_q) + 9'd1 == 9'(rh_q)) ? ST_RES : ST_SETUP;
							end else begin
								phase_q <= phase_q + 1'b1;
								state_q <= (phase_q == 3'd3) ? ST_RES : ST_SETUP;
							end
						end
						CMD_CIRCLE: begin
							if ((fill_q && phase_q == 3'd3) || (!fill_q && phase_q == 3'd7)) begin
								phase_q <= '0;
								cxv_q   <= x1;
								cyv_q   <= y1;
								m_q     <= m2;
								state_q <= (x1 <= y1) ? ST_SETUP : ST_RES;
							end else begin
								phase_q <= phase_q + 1'b1;
								state_q <= ST_SETUP;
							end
						end
						default: state_q <= ST_RES;
					endcase
				end
				ST_FILL: begin
					if (sweep_q == used) begin
						state_q <= ST_RES;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_RD1: begin
					if (16'(bidx_q) < 16'(used)) begin
						state_q <= ST_RD2;
					end else begin
						ok_q    <= 1'b0;
						state_q <= ST_RES;
					end
				end
				ST_RD2: begin
					rb_q    <= ram_rdata;
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= rb_q;
						out_ok_q    <= ok_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/mono_framebuffer_draw_engine.sv
// Sequence: a plotted pixel is a read-modify-write of one byte (read state, then write state);
// a clipped one is skipped in the read state; each segment adds a setup state, an end-of-segment
// check and an advance state. Each command leaves the queue in the idle state and loads the
// output register in the result state; fill sweeps the used bytes, a read uses the read states.
// Throughput: one command at a time in the drawing unit, with a two-entry command queue ahead.
// Reset: asynchronous and active low; afterwards a pass over every byte clears the framebuffer,
// during which no command transaction is accepted.
module mono_framebuffer_draw_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// x_start[8:0], y_start[17:9], x_end[26:18], y_end[35:27], rect_width[43:36],
	// rect_height[51:44], circle_radius[59:52], filled[60], colour[61], byte_index[71:62]
	input  logic [71:0] s_axis_tdata,
	// func[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_byte[7:0], index_ok[8], zero[15:9]
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mfde_pkg::*;

	queue_head_t  head;
	back_status_t status;

	mfde_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.head          (head),
		.status        (status)
	);

	mfde_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// File: sv/mfde_checker.sv
`include "mono_framebuffer_draw_engine_assert.svh"

module mfde_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [71:0] s_axis_tdata,
	input logic [2:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [7:0]  cfg_data
);

	`MFDE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`MFDE_ASSERT_NOW(a_bad_read_zero, m_axis_tvalid && !m_axis_tdata[8], m_axis_tdata[7:0] == 8'd0)
	`MFDE_ASSERT_NOW(a_clear_blocks, !$past(arst_n), !s_axis_tready)

endmodule

bind mono_framebuffer_draw_engine mfde_checker u_checker (.*);
